// ===== rtl/multi_waveform_oscillator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the oscillator core
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_OSCILLATOR_CORE_MACROS_SVH
`define MULTI_WAVEFORM_OSCILLATOR_CORE_MACROS_SVH
`ifndef SYNTH
// Check a property at every rising edge outside reset
`define MWO_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mwo: assertion failed");
// Check a condition that must hold at every rising edge outside reset
`define MWO_INVARIANT(lbl, clk, rst_n, cond) \
  `MWO_ASSERT(lbl, clk, rst_n, cond)
`else
`define MWO_ASSERT(lbl, clk, rst_n, prop)
`define MWO_INVARIANT(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/mwo_pkg.sv =====
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared constants, codes and types of the multi-waveform oscillator.
// ----------------------------------------------------------------------------
`default_nettype none

package mwo_pkg;

  // Field and register widths
  localparam int PHASE_BITS    = 32;
  localparam int STEP_BITS     = 32;
  localparam int AMP_BITS      = 16;
  localparam int WAVE_BITS     = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int SAMPLE_BITS   = 16;

  // Quarter-wave sine: index, polynomial fraction and operand widths
  localparam int TBL_DEPTH    = 1024;
  localparam int TBL_IDX_BITS = $clog2(TBL_DEPTH);
  localparam int K_BITS       = TBL_IDX_BITS + 1;
  localparam int FRAC_BITS    = 30;
  localparam int POLY_BITS    = FRAC_BITS + 1;
  localparam int X_SHIFT      = FRAC_BITS - TBL_IDX_BITS;

  // Waveform value in Q2.15, range [-1, +1] inclusive
  localparam int Q15_BITS = 15;
  localparam int VAL_BITS = Q15_BITS + 2;
  localparam logic signed [VAL_BITS-1:0] VAL_ONE = VAL_BITS'(2 ** Q15_BITS);

  // Gain stage
  localparam int SCALE_SHIFT = 31 - SAMPLE_BITS;
  localparam int PROD_BITS   = VAL_BITS + AMP_BITS + 1;

  // Noise generator
  localparam int LFSR_BITS = 32;
  localparam logic [LFSR_BITS-1:0] LFSR_SEED = 32'h0000_ACE1;
  localparam logic [LFSR_BITS-1:0] LFSR_TAPS = 32'h8020_0003;

  // Decoupling queue
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = QPTR_BITS + 1;

  // Reset value of the gain: unity
  localparam logic [AMP_BITS-1:0] AMP_RESET = AMP_BITS'(2 ** Q15_BITS);

  // Sine polynomial coefficients, fraction of 2^30
  localparam logic [POLY_BITS-1:0] COEF_A1 = 31'd1686629713;
  localparam logic [POLY_BITS-1:0] COEF_A3 = 31'd693598668;
  localparam logic [POLY_BITS-1:0] COEF_A5 = 31'd85569305;
  localparam logic [POLY_BITS-1:0] COEF_A7 = 31'd5026994;

  typedef enum logic [WAVE_BITS-1:0] {
    WAVE_SINE     = 3'd0,
    WAVE_SAW      = 3'd1,
    WAVE_SQUARE   = 3'd2,
    WAVE_TRIANGLE = 3'd3,
    WAVE_NOISE    = 3'd4
  } mwo_wave_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_AMPLITUDE  = 2'd1,
    CFG_WAVEFORM   = 2'd2,
    CFG_BYPASS     = 2'd3
  } mwo_cfg_idx_t;

  typedef struct packed {
    logic [STEP_BITS-1:0] phase_step;
    logic [AMP_BITS-1:0]  amplitude;
    logic [WAVE_BITS-1:0] waveform;
    logic                 bypass;
  } mwo_cfg_t;

  // One classified tick: either a sine polynomial evaluation or a ready-made value
  typedef struct packed {
    logic                       is_sine;
    logic                       neg;
    logic [K_BITS-1:0]          k;
    logic signed [VAL_BITS-1:0] value;
    logic                       last;
  } mwo_op_t;

endpackage

`default_nettype wire

// ===== rtl/mwo_if.sv =====
// ----------------------------------------------------------------------------
// mwo_in_if / mwo_out_if
// Valid/ready channels for tick items and sample items.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwo_in_if;
  logic valid;
  logic ready;
  logic restart_phase;
  logic block_last;

  modport source (output valid, output restart_phase, output block_last, input ready);
  modport sink (input valid, input restart_phase, input block_last, output ready);
endinterface

interface mwo_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mwo_pkg::SAMPLE_BITS-1:0] sample_out;
  logic                                 block_end;

  modport source (output valid, output sample_out, output block_end, input ready);
  modport sink (input valid, input sample_out, input block_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/mwo_queue.sv =====
// ----------------------------------------------------------------------------
// mwo_queue
// Short FIFO of classified ticks between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_waveform_oscillator_core_macros.svh"

module mwo_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  mwo_pkg::mwo_op_t push_op,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output mwo_pkg::mwo_op_t pop_op
);
  import mwo_pkg::*;

  mwo_op_t              q_r [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QCNT_BITS-1:0] cnt_r;
  logic [QCNT_BITS-1:0] cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign push_ready = (cnt_r != QCNT_BITS'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_op     = q_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Track fill level
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - QCNT_BITS'(1);
    end
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_BITS'(1);
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_op;
    end
  end

  `MWO_INVARIANT(a_q_bound, clk, rst_n, cnt_r <= QCNT_BITS'(QDEPTH))
  `MWO_ASSERT(a_q_fill, clk, rst_n, do_push && !do_pop |=> cnt_r == $past(cnt_r) + QCNT_BITS'(1))

endmodule

`default_nettype wire

// ===== rtl/mwo_front.sv =====
// ----------------------------------------------------------------------------
// mwo_front
// Accept ticks, run the phase accumulator and noise LFSR, classify each tick.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_waveform_oscillator_core_macros.svh"

module mwo_front (
  input  logic             clk,
  input  logic             rst_n,
  mwo_in_if.sink           in_ch,
  input  mwo_pkg::mwo_cfg_t cfg,
  input  logic             q_ready,
  output logic             q_push,
  output mwo_pkg::mwo_op_t q_op
);
  import mwo_pkg::*;

  logic [PHASE_BITS-1:0]   phase_r;
  logic [PHASE_BITS-1:0]   phase_nxt;
  logic [PHASE_BITS-1:0]   ph_cur;
  logic [LFSR_BITS-1:0]    lfsr_r;
  logic [LFSR_BITS-1:0]    lfsr_nxt;
  logic [LFSR_BITS-1:0]    lfsr_step;
  logic [1:0]              quarter;
  logic [TBL_IDX_BITS-1:0] tbl_idx;
  logic [Q15_BITS-1:0]     p15;
  logic                    low_half;
  logic [VAL_BITS-1:0]     tri_u;
  logic                    noise_sel;

  assign in_ch.ready = q_ready;
  assign q_push      = in_ch.valid && q_ready;

  // Phase seen by this tick, after an optional restart
  assign ph_cur   = in_ch.restart_phase ? '0 : phase_r;
  assign quarter  = ph_cur[PHASE_BITS-1 -: 2];
  assign tbl_idx  = ph_cur[PHASE_BITS-3 -: TBL_IDX_BITS];
  assign p15      = ph_cur[PHASE_BITS-1 -: Q15_BITS];
  assign low_half = !p15[Q15_BITS-1];
  assign tri_u    = {1'b0, p15[Q15_BITS-2:0], 2'b00};

  // Galois LFSR, shift right
  assign lfsr_step = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);
  assign noise_sel = (cfg.waveform == WAVE_NOISE);

  // Classify the tick
  always_comb begin
    q_op.is_sine = 1'b0;
    q_op.neg     = quarter[1];
    q_op.k       = quarter[0] ? (K_BITS'(TBL_DEPTH) - {1'b0, tbl_idx}) : {1'b0, tbl_idx};
    q_op.value   = '0;
    q_op.last    = in_ch.block_last;
    if (!cfg.bypass) begin
      case (cfg.waveform)
        WAVE_SINE: begin
          q_op.is_sine = 1'b1;
        end
        WAVE_SAW: begin
          q_op.value = $signed({1'b0, p15, 1'b0}) - VAL_ONE;
        end
        WAVE_SQUARE: begin
          q_op.value = low_half ? VAL_ONE : -VAL_ONE;
        end
        WAVE_TRIANGLE: begin
          q_op.value = low_half ? ($signed(tri_u) - VAL_ONE) : (VAL_ONE - $signed(tri_u));
        end
        WAVE_NOISE: begin
          q_op.value = $signed({1'b0, lfsr_step[LFSR_BITS-1 -: 16]}) - VAL_ONE;
        end
        default: begin
          q_op.value = '0;
        end
      endcase
    end
  end

  // Advance phase unless bypassed; step noise only when it is used
  always_comb begin
    phase_nxt = phase_r;
    lfsr_nxt  = lfsr_r;
    if (q_push) begin
      phase_nxt = cfg.bypass ? ph_cur : ph_cur + PHASE_BITS'(cfg.phase_step);
      if (!cfg.bypass && noise_sel) begin
        lfsr_nxt = lfsr_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      lfsr_r  <= LFSR_SEED;
    end else begin
      phase_r <= phase_nxt;
      lfsr_r  <= lfsr_nxt;
    end
  end

  `MWO_ASSERT(a_bypass_hold, clk, rst_n, q_push && cfg.bypass && !in_ch.restart_phase |=> phase_r == $past(phase_r))
  `MWO_INVARIANT(a_lfsr_live, clk, rst_n, lfsr_r != '0)

endmodule

`default_nettype wire

// ===== rtl/mwo_back.sv =====
// ----------------------------------------------------------------------------
// mwo_back
// Evaluate the sine polynomial, apply gain, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module mwo_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  mwo_pkg::mwo_op_t              q_op,
  output logic                          q_pop,
  input  logic [mwo_pkg::AMP_BITS-1:0]  amplitude,
  mwo_out_if.source                     out_ch
);
  import mwo_pkg::*;

  localparam int POLY_STAGES = 4;
  localparam int MUL_BITS    = 2 * POLY_BITS;
  localparam int RND_BITS    = POLY_BITS + 1;
  localparam logic [VAL_BITS-1:0] T_MAX = VAL_BITS'(2 ** Q15_BITS);
  localparam logic [RND_BITS-1:0] T_BIAS = RND_BITS'(2 ** (Q15_BITS - 1));
  localparam logic signed [PROD_BITS-1:0] RND_BIAS = PROD_BITS'(2 ** (SCALE_SHIFT - 1));
  localparam logic signed [PROD_BITS-1:0] SAT_HI = PROD_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [PROD_BITS-1:0] SAT_LO = -SAT_HI - PROD_BITS'(1);

  typedef struct packed {
    mwo_op_t              op;
    logic [POLY_BITS-1:0] x;
    logic [POLY_BITS-1:0] x2;
    logic [POLY_BITS-1:0] t;
  } poly_t;

  poly_t                       ps_r   [POLY_STAGES];
  poly_t                       ps_nxt [POLY_STAGES];
  logic [POLY_STAGES-1:0]      pv_r;
  logic [MUL_BITS-1:0]         mul [POLY_STAGES+1];
  logic [POLY_BITS-1:0]        x_in;
  logic [POLY_BITS-1:0]        s_val;
  logic [RND_BITS-1:0]         s_rnd;
  logic [VAL_BITS-1:0]         t_q;
  logic [VAL_BITS-1:0]         t_cl;
  logic signed [VAL_BITS-1:0]  v_nxt;
  logic signed [VAL_BITS-1:0]  v_r;
  logic                        vlast_r;
  logic                        vv_r;
  logic signed [PROD_BITS-1:0] prod_nxt;
  logic signed [PROD_BITS-1:0] prod_r;
  logic                        plast_r;
  logic                        mv_r;
  logic signed [PROD_BITS-1:0] rnd;
  logic [SAMPLE_BITS-1:0]      sample_nxt;
  logic [SAMPLE_BITS-1:0]      sample_r;
  logic                        end_r;
  logic                        ov_r;
  logic                        adv;

  // Whole pipeline moves when the output register is free or being taken
  assign adv   = !ov_r || out_ch.ready;
  assign q_pop = adv && q_valid;

  // Polynomial stages: x^2, then Horner steps for A5, A3, A1
  assign x_in = POLY_BITS'(q_op.k) << X_SHIFT;
  assign mul[0] = MUL_BITS'(x_in) * MUL_BITS'(x_in);
  assign mul[1] = MUL_BITS'(ps_r[0].x2) * MUL_BITS'(COEF_A7);
  assign mul[2] = MUL_BITS'(ps_r[1].x2) * MUL_BITS'(ps_r[1].t);
  assign mul[3] = MUL_BITS'(ps_r[2].x2) * MUL_BITS'(ps_r[2].t);
  assign mul[4] = MUL_BITS'(ps_r[3].x) * MUL_BITS'(ps_r[3].t);

  always_comb begin
    ps_nxt[0].op = q_op;
    ps_nxt[0].x  = x_in;
    ps_nxt[0].x2 = mul[0][FRAC_BITS +: POLY_BITS];
    ps_nxt[0].t  = '0;
    ps_nxt[1]    = ps_r[0];
    ps_nxt[1].t  = COEF_A5 - mul[1][FRAC_BITS +: POLY_BITS];
    ps_nxt[2]    = ps_r[1];
    ps_nxt[2].t  = COEF_A3 - mul[2][FRAC_BITS +: POLY_BITS];
    ps_nxt[3]    = ps_r[2];
    ps_nxt[3].t  = COEF_A1 - mul[3][FRAC_BITS +: POLY_BITS];
  end

  // Round the sine to Q2.15, clamp at one, apply the quadrant sign
  assign s_val = mul[4][FRAC_BITS +: POLY_BITS];
  assign s_rnd = {1'b0, s_val} + T_BIAS;
  assign t_q   = s_rnd[Q15_BITS +: VAL_BITS];
  assign t_cl  = (t_q > T_MAX) ? T_MAX : t_q;

  always_comb begin
    v_nxt = ps_r[POLY_STAGES-1].op.value;
    if (ps_r[POLY_STAGES-1].op.is_sine) begin
      v_nxt = ps_r[POLY_STAGES-1].op.neg ? -$signed(t_cl) : $signed(t_cl);
    end
  end

  // Gain
  assign prod_nxt = PROD_BITS'(v_r) * PROD_BITS'($signed({1'b0, amplitude}));

  // Round half up and saturate
  assign rnd = (prod_r + RND_BIAS) >>> SCALE_SHIFT;

  always_comb begin
    sample_nxt = rnd[SAMPLE_BITS-1:0];
    if (rnd > SAT_HI) begin
      sample_nxt = SAT_HI[SAMPLE_BITS-1:0];
    end else if (rnd < SAT_LO) begin
      sample_nxt = SAT_LO[SAMPLE_BITS-1:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      vv_r <= 1'b0;
      mv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      pv_r <= {pv_r[POLY_STAGES-2:0], q_valid};
      vv_r <= pv_r[POLY_STAGES-1];
      mv_r <= vv_r;
      ov_r <= mv_r;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      ps_r     <= ps_nxt;
      v_r      <= v_nxt;
      vlast_r  <= ps_r[POLY_STAGES-1].op.last;
      prod_r   <= prod_nxt;
      plast_r  <= vlast_r;
      sample_r <= sample_nxt;
      end_r    <= plast_r;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.sample_out = $signed(sample_r);
  assign out_ch.block_end  = end_r;

endmodule

`default_nettype wire

// ===== rtl/multi_waveform_oscillator_core.sv =====
// ----------------------------------------------------------------------------
// multi_waveform_oscillator_core: sine/saw/square/triangle/noise NCO
// Throughput one tick per cycle while the output is not stalled; a result passes through
// the queue, the five pipelined sine polynomial multiplies, and the gain and
// rounding stages of the back end; an output stall freezes the back end.
// Sync reset: phase 0, noise seed 0xACE1, unity gain, sine, queue and pipeline empty.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_waveform_oscillator_core (
  input  logic                               clk,
  input  logic                               rst_n,
  mwo_in_if.sink                             in_ch,
  mwo_out_if.source                          out_ch,
  input  logic                               cfg_wr_en,
  input  logic [mwo_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [mwo_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import mwo_pkg::*;

  mwo_cfg_t cfg_r;
  logic     q_push;
  logic     q_ready;
  mwo_op_t  q_push_op;
  logic     q_pop;
  logic     q_valid;
  mwo_op_t  q_pop_op;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{phase_step: '0, amplitude: AMP_RESET, waveform: WAVE_SINE, bypass: 1'b0};
    end else if (cfg_wr_en) begin
      case (mwo_cfg_idx_t'(cfg_index))
        CFG_PHASE_STEP: cfg_r.phase_step <= cfg_data[STEP_BITS-1:0];
        CFG_AMPLITUDE:  cfg_r.amplitude  <= cfg_data[AMP_BITS-1:0];
        CFG_WAVEFORM:   cfg_r.waveform   <= cfg_data[WAVE_BITS-1:0];
        CFG_BYPASS:     cfg_r.bypass     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  mwo_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .cfg     (cfg_r),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_op    (q_push_op)
  );

  mwo_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_op     (q_pop_op)
  );

  mwo_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_op      (q_pop_op),
    .q_pop     (q_pop),
    .amplitude (cfg_r.amplitude),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
